>>> src/nbody_force_jerk_accumulator_macros.svh
// Assertion macros for the force and jerk accumulator checker.
// Depends on nothing; included by the checker file only.
`ifndef NBODY_FORCE_JERK_ACCUMULATOR_MACROS_SVH
`define NBODY_FORCE_JERK_ACCUMULATOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define NFJA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("accumulator port rule violated");

// Check a consequent in the cycle after its antecedent
`define NFJA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("accumulator port rule violated");

`endif

>>> src/nfja_pkg.sv
// Shared types, constants and saturation helpers for the force and jerk accumulator.
// Depends on nothing; used by the arithmetic unit and the top level.
package nfja_pkg;

   localparam int unsigned WIDE_W = 128;

   // Step counts of the bit-serial unit, minus one
   localparam logic [6:0] MUL_LAST  = 7'd63;
   localparam logic [6:0] DIV_LAST  = 7'd127;
   localparam logic [6:0] SQRT_LAST = 7'd31;

   localparam logic signed [47:0] POS48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] NEG48 = 48'sh8000_0000_0000;
   localparam logic [47:0]        MAX48 = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [WIDE_W-1:0] a;
      logic [WIDE_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic              busy;
      logic [WIDE_W-1:0] result;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ,
      ST_CHK,
      ST_ROOT,
      ST_CUBE,
      ST_MASS,
      ST_DOT,
      ST_FMUL,
      ST_FDIV,
      ST_CMUL,
      ST_CDIV,
      ST_JMUL,
      ST_JDIV,
      ST_MINUP,
      ST_DTFF,
      ST_DTV,
      ST_OUT
   } state_type;

   // Clamp a magnitude with a sign to 48 bit signed
   function automatic logic signed [47:0] sat_signed(logic [WIDE_W-1:0] m, logic neg);
      logic [47:0] t;
      t = ~m[47:0] + 48'd1;
      if (neg) begin
         if (m[WIDE_W-1:48] != '0 || m[47:0] > 48'h8000_0000_0000) return NEG48;
         return $signed(t);
      end
      if (m[WIDE_W-1:47] != '0) return POS48;
      return $signed(m[47:0]);
   endfunction

   // Add two 48 bit signed values with saturation
   function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                  logic signed [47:0] b);
      logic signed [48:0] s;
      s = {a[47], a} + {b[47], b};
      if (!s[48] && s[47]) return POS48;
      if (s[48] && !s[47]) return NEG48;
      return s[47:0];
   endfunction

   // Clamp an unsigned value to 48 bits
   function automatic logic [47:0] sat_unsigned(logic [WIDE_W-1:0] m);
      if (m[WIDE_W-1:48] != '0) return MAX48;
      return m[47:0];
   endfunction

   // Magnitude of a 32 bit signed value
   function automatic logic [31:0] mag32(logic signed [31:0] v);
      if (v[31]) return 32'(-v);
      return v;
   endfunction

endpackage

>>> src/nfja_alu.sv
// Bit-serial shared unit: shift-add multiply, restoring divide and integer root.
// Depends on nfja_pkg; all three operations share one 128 bit adder.
module nfja_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  nfja_pkg::alu_req_type req,
   output nfja_pkg::alu_rsp_type rsp
);
   import nfja_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   alu_op_type          op_ff, op_in;
   logic [6:0]          cnt_ff, cnt_in;
   logic [WIDE_W-1:0]   src_ff, src_in;
   logic [WIDE_W-1:0]   opnd_ff, opnd_in;
   logic [WIDE_W-1:0]   rem_ff, rem_in;
   logic [WIDE_W-1:0]   acc_ff, acc_in;

   logic [WIDE_W-1:0]   add_x, add_y;
   logic                add_sub;
   logic [WIDE_W:0]     add_sum;

   // Select adder operands for the current step
   always_comb begin
      add_x   = {acc_ff[WIDE_W-2:0], 1'b0};
      add_y   = opnd_ff;
      add_sub = 1'b0;
      unique case (op_ff)
         ALU_MUL: begin
            add_x   = {acc_ff[WIDE_W-2:0], 1'b0};
            add_y   = opnd_ff;
            add_sub = 1'b0;
         end
         ALU_DIV: begin
            add_x   = {rem_ff[WIDE_W-2:0], src_ff[WIDE_W-1]};
            add_y   = opnd_ff;
            add_sub = 1'b1;
         end
         ALU_SQRT: begin
            add_x   = {rem_ff[WIDE_W-3:0], src_ff[WIDE_W-1:WIDE_W-2]};
            add_y   = {acc_ff[WIDE_W-3:0], 2'b01};
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
      add_sum = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y} + (WIDE_W+1)'(add_sub);
   end

   // Load an operation or advance one step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      src_in  = src_ff;
      opnd_in = opnd_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         acc_in  = '0;
         rem_in  = '0;
         unique case (req.op)
            ALU_MUL: begin
               src_in  = {req.b[63:0], 64'b0};
               opnd_in = req.a;
               cnt_in  = MUL_LAST;
            end
            ALU_DIV: begin
               src_in  = req.a;
               opnd_in = req.b;
               cnt_in  = DIV_LAST;
            end
            ALU_SQRT: begin
               src_in  = {req.a[63:0], 64'b0};
               opnd_in = '0;
               cnt_in  = SQRT_LAST;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               src_in = {src_ff[WIDE_W-2:0], 1'b0};
               acc_in = src_ff[WIDE_W-1] ? add_sum[WIDE_W-1:0] : add_x;
            end
            ALU_DIV, ALU_SQRT: begin
               if (op_ff == ALU_DIV) src_in = {src_ff[WIDE_W-2:0], 1'b0};
               else                  src_in = {src_ff[WIDE_W-3:0], 2'b00};
               rem_in = add_sum[WIDE_W] ? add_sum[WIDE_W-1:0] : add_x;
               acc_in = {acc_ff[WIDE_W-2:0], add_sum[WIDE_W]};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      src_ff  <= src_in;
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
   end

   assign rsp = '{done: done_ff, busy: busy_ff, result: acc_ff};

endmodule

>>> src/nbody_force_jerk_accumulator.sv
// Force and jerk accumulator: top level with sequencer, sums and result register.
// Depends on nfja_pkg and nfja_alu.
//
// Each request is one leaf-pair interaction; the block sums mi*mj*dx/r^3 into the
// force and the Hermite jerk term into the jerk, keeps the closest approach, and on
// a request with tlast high returns force, jerk and the squared step, then clears.
// All arithmetic runs on one bit-serial unit, one operation at a time. A request runs
// 3 squares, root, cube, mass, 3 dot terms, then per axis three multiplies and three
// divides; a last request adds up to two step divides and the result load, and a
// coincident pair runs only the squares. req_tready is high only while idle; a finished
// result waits in its own register and does not hold the next request.
module nbody_force_jerk_accumulator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mass_i[30:0] mass_j[61:31] rel_pos_x/y/z[157:62] rel_vel_x/y/z[253:158]
   // pair_mass[285:254] node_vel_sq[333:286], zero fill [335:334]
   input  logic [335:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x/y/z[143:0] jerk_x/y/z[287:144] step_sq[335:288]
   output logic [335:0] rsp_tdata
);
   import nfja_pkg::*;

   state_type          state_ff, state_in;
   logic               issued_ff, issued_in;
   logic [1:0]         k_ff, k_in;

   logic [30:0]        mi_ff, mi_in, mj_ff, mj_in;
   logic signed [31:0] dx_ff [3];
   logic signed [31:0] dx_in [3];
   logic signed [31:0] dv_ff [3];
   logic signed [31:0] dv_in [3];
   logic [31:0]        pm_ff, pm_in;
   logic [47:0]        vsq_ff, vsq_in;
   logic               last_ff, last_in;

   logic [63:0]        r2_ff, r2_in;
   logic [31:0]        r_ff, r_in;
   logic [95:0]        r3_ff, r3_in;
   logic [61:0]        m2_ff, m2_in;
   logic signed [66:0] dot_ff, dot_in;
   logic [WIDE_W-1:0]  prod_ff, prod_in;
   logic signed [63:0] w_ff, w_in;

   logic signed [47:0] force_ff [3];
   logic signed [47:0] force_in [3];
   logic signed [47:0] jerk_ff [3];
   logic signed [47:0] jerk_in [3];
   logic [47:0]        min_sq_ff, min_sq_in;
   logic [47:0]        min_cube_ff, min_cube_in;
   logic [47:0]        dtff_ff, dtff_in;
   logic [47:0]        step_ff, step_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [335:0]       rsp_data_ff, rsp_data_in;

   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;
   logic               op_valid;

   logic [31:0]        adx, adv;
   logic               xneg, dot_neg;
   logic [66:0]        dot_abs;
   logic [63:0]        dmag;
   logic [33:0]        adx3;
   logic               w_neg;
   logic [63:0]        wmag;
   logic [WIDE_W-1:0]  res;
   logic [63:0]        c_signed;
   logic [66:0]        dot_term;
   logic [47:0]        dt_cand;

   nfja_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // Per-axis operands and signs
   always_comb begin
      res      = alu_rsp.result;
      adx      = mag32(dx_ff[k_ff]);
      adv      = mag32(dv_ff[k_ff]);
      xneg     = dx_ff[k_ff][31];
      dot_neg  = dot_ff[66];
      dot_abs  = dot_neg ? 67'(-dot_ff) : 67'(dot_ff);
      dmag     = dot_abs[63:0];
      adx3     = {2'b00, adx} + {1'b0, adx, 1'b0};
      w_neg    = w_ff[63];
      wmag     = w_neg ? 64'(-w_ff) : 64'(w_ff);
      c_signed = (xneg != dot_neg) ? (~res[63:0] + 64'd1) : res[63:0];
      dot_term = (dx_ff[k_ff][31] ^ dv_ff[k_ff][31]) ? 67'(-{4'b0000, res[62:0]})
                                                     : {4'b0000, res[62:0]};
      dt_cand  = sat_unsigned(res);
   end

   // Sequencer: next state, operation issue and register updates
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      mi_in        = mi_ff;
      mj_in        = mj_ff;
      dx_in        = dx_ff;
      dv_in        = dv_ff;
      pm_in        = pm_ff;
      vsq_in       = vsq_ff;
      last_in      = last_ff;
      r2_in        = r2_ff;
      r_in         = r_ff;
      r3_in        = r3_ff;
      m2_in        = m2_ff;
      dot_in       = dot_ff;
      prod_in      = prod_ff;
      w_in         = w_ff;
      force_in     = force_ff;
      jerk_in      = jerk_ff;
      min_sq_in    = min_sq_ff;
      min_cube_in  = min_cube_ff;
      dtff_in      = dtff_ff;
      step_in      = step_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      op_valid     = 1'b0;
      alu_req      = '{start: 1'b0, op: ALU_MUL, a: '0, b: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mi_in    = req_tdata[30:0];
               mj_in    = req_tdata[61:31];
               dx_in[0] = req_tdata[93:62];
               dx_in[1] = req_tdata[125:94];
               dx_in[2] = req_tdata[157:126];
               dv_in[0] = req_tdata[189:158];
               dv_in[1] = req_tdata[221:190];
               dv_in[2] = req_tdata[253:222];
               pm_in    = req_tdata[285:254];
               vsq_in   = req_tdata[333:286];
               last_in  = req_tlast;
               k_in     = 2'd0;
               r2_in    = '0;
               dot_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            op_valid  = 1'b1;
            alu_req.a = WIDE_W'(adx);
            alu_req.b = WIDE_W'(adx);
            if (alu_rsp.done) begin
               r2_in = r2_ff + res[63:0];
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_CHK;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_CHK: begin
            // coincident pair adds nothing and counts as distance zero
            if (r2_ff == '0) begin
               r3_in    = '0;
               state_in = ST_MINUP;
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            op_valid   = 1'b1;
            alu_req.op = ALU_SQRT;
            alu_req.a  = WIDE_W'(r2_ff);
            if (alu_rsp.done) begin
               r_in     = res[31:0];
               state_in = ST_CUBE;
            end
         end
         ST_CUBE: begin
            op_valid  = 1'b1;
            alu_req.a = WIDE_W'(r2_ff);
            alu_req.b = WIDE_W'(r_ff);
            if (alu_rsp.done) begin
               r3_in    = res[95:0];
               state_in = ST_MASS;
            end
         end
         ST_MASS: begin
            op_valid  = 1'b1;
            alu_req.a = WIDE_W'(mi_ff);
            alu_req.b = WIDE_W'(mj_ff);
            if (alu_rsp.done) begin
               m2_in    = res[61:0];
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            op_valid  = 1'b1;
            alu_req.a = WIDE_W'(adx);
            alu_req.b = WIDE_W'(adv);
            if (alu_rsp.done) begin
               dot_in = dot_ff + $signed(dot_term);
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_FMUL;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_FMUL: begin
            op_valid  = 1'b1;
            alu_req.a = WIDE_W'(m2_ff);
            alu_req.b = WIDE_W'(adx);
            if (alu_rsp.done) begin
               prod_in  = res;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            op_valid   = 1'b1;
            alu_req.op = ALU_DIV;
            alu_req.a  = {prod_ff[WIDE_W-25:0], 24'b0};
            alu_req.b  = WIDE_W'(r3_ff);
            if (alu_rsp.done) begin
               force_in[k_ff] = sat_add(force_ff[k_ff], sat_signed(res, xneg));
               state_in       = ST_CMUL;
            end
         end
         ST_CMUL: begin
            op_valid  = 1'b1;
            alu_req.a = WIDE_W'(dmag);
            alu_req.b = WIDE_W'(adx3);
            if (alu_rsp.done) begin
               prod_in  = res;
               state_in = ST_CDIV;
            end
         end
         ST_CDIV: begin
            op_valid   = 1'b1;
            alu_req.op = ALU_DIV;
            alu_req.a  = prod_ff;
            alu_req.b  = WIDE_W'(r2_ff);
            if (alu_rsp.done) begin
               w_in     = 64'(dv_ff[k_ff]) - $signed(c_signed);
               state_in = ST_JMUL;
            end
         end
         ST_JMUL: begin
            op_valid  = 1'b1;
            alu_req.a = WIDE_W'(m2_ff);
            alu_req.b = WIDE_W'(wmag);
            if (alu_rsp.done) begin
               prod_in  = res;
               state_in = ST_JDIV;
            end
         end
         ST_JDIV: begin
            op_valid   = 1'b1;
            alu_req.op = ALU_DIV;
            alu_req.a  = {prod_ff[WIDE_W-25:0], 24'b0};
            alu_req.b  = WIDE_W'(r3_ff);
            if (alu_rsp.done) begin
               jerk_in[k_ff] = sat_add(jerk_ff[k_ff], sat_signed(res, w_neg));
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_MINUP;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_FMUL;
               end
            end
         end
         ST_MINUP: begin
            // replace both minima on a strictly closer pair
            if (r2_ff[63:16] < min_sq_ff) begin
               min_sq_in   = r2_ff[63:16];
               min_cube_in = r3_ff[95:48];
            end
            state_in = last_ff ? ST_DTFF : ST_IDLE;
         end
         ST_DTFF: begin
            if (pm_ff == '0) begin
               dtff_in  = MAX48;
               state_in = ST_DTV;
            end else begin
               op_valid   = 1'b1;
               alu_req.op = ALU_DIV;
               alu_req.a  = WIDE_W'({min_cube_ff, 23'b0});
               alu_req.b  = WIDE_W'(pm_ff);
               if (alu_rsp.done) begin
                  dtff_in  = dt_cand;
                  state_in = ST_DTV;
               end
            end
         end
         ST_DTV: begin
            if (vsq_ff == '0) begin
               step_in  = dtff_ff;
               state_in = ST_OUT;
            end else begin
               op_valid   = 1'b1;
               alu_req.op = ALU_DIV;
               alu_req.a  = WIDE_W'({min_sq_ff, 16'b0});
               alu_req.b  = WIDE_W'(vsq_ff);
               if (alu_rsp.done) begin
                  step_in  = (dt_cand < dtff_ff) ? dt_cand : dtff_ff;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            // load the result once the register is free, then clear the sums and minima
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {step_ff, jerk_ff[2], jerk_ff[1], jerk_ff[0],
                               force_ff[2], force_ff[1], force_ff[0]};
               rsp_valid_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  force_in[i] = '0;
                  jerk_in[i]  = '0;
               end
               min_sq_in   = MAX48;
               min_cube_in = MAX48;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // issue each operation once; a done from the unit clears the mark for the next
      alu_req.start = op_valid && !issued_ff && !alu_rsp.busy;
      if (alu_rsp.done)       issued_in = 1'b0;
      else if (alu_req.start) issued_in = 1'b1;
      else                    issued_in = issued_ff;
   end

   // Control state and running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_sq_ff    <= MAX48;
         min_cube_ff  <= MAX48;
         for (int i = 0; i < 3; i++) begin
            force_ff[i] <= '0;
            jerk_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         min_sq_ff    <= min_sq_in;
         min_cube_ff  <= min_cube_in;
         force_ff     <= force_in;
         jerk_ff      <= jerk_in;
      end
   end

   // Request payload and intermediate values
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      mi_ff       <= mi_in;
      mj_ff       <= mj_in;
      dx_ff       <= dx_in;
      dv_ff       <= dv_in;
      pm_ff       <= pm_in;
      vsq_ff      <= vsq_in;
      last_ff     <= last_in;
      r2_ff       <= r2_in;
      r_ff        <= r_in;
      r3_ff       <= r3_in;
      m2_ff       <= m2_in;
      dot_ff      <= dot_in;
      prod_ff     <= prod_in;
      w_ff        <= w_in;
      dtff_ff     <= dtff_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> src/nfja_checker.sv
// Port-level checks for the force and jerk accumulator, bound to the top level.
// Depends on nbody_force_jerk_accumulator_macros.svh.
`include "nbody_force_jerk_accumulator_macros.svh"

module nfja_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [335:0] rsp_tdata
);

   // A stalled result holds
   `NFJA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // An accepted request keeps the block busy
   `NFJA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // A new result is loaded only from a busy block
   `NFJA_ASSERT_SAME(a_result_from_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind nbody_force_jerk_accumulator nfja_checker u_checker (.*);

>>> tb/nbody_force_jerk_accumulator_checker.sv
// Checker for the force and jerk accumulator: predicts each frame result from the requests
// it sees and compares the result stream field by field. Depends on nfja_pkg for limits.
`timescale 1ns / 1ps

module nbody_force_jerk_accumulator_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [335:0] req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [335:0] rsp_tdata,
   output int           fail_count,
   output int           pending_count,
   output int           frame_count
);
   import nfja_pkg::*;

   typedef struct {
      logic signed [47:0] frc[3];
      logic signed [47:0] jrk[3];
      logic [47:0]        step;
   } frame_sums_type;

   // Running sums and closest approach of the current frame
   logic signed [47:0] force_acc[3];
   logic signed [47:0] jerk_acc[3];
   logic [47:0]        closest_sq;
   logic [47:0]        closest_cube;
   frame_sums_type     frames_due[$];

   // Integer square root, floor
   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt = bt >> 2;
      while (bt != 0) begin
         if (x >= res + bt) begin
            x = x - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // Clamp a magnitude with a sign to 48 bit signed
   function automatic logic signed [47:0] clamp_term(logic [127:0] m, logic neg);
      if (neg) begin
         if (m > 128'h8000_0000_0000) return NEG48;
         return -$signed(m[47:0]);
      end
      if (m > 128'h7FFF_FFFF_FFFF) return POS48;
      return $signed(m[47:0]);
   endfunction

   // Saturating 48 bit signed add
   function automatic logic signed [47:0] add_clamped(logic signed [47:0] a,
                                                      logic signed [47:0] b);
      logic signed [49:0] s;
      s = 50'(a) + 50'(b);
      if (s > 50'(POS48)) return POS48;
      if (s < 50'(NEG48)) return NEG48;
      return s[47:0];
   endfunction

   function automatic logic [47:0] clamp_step(logic [127:0] m);
      if (m[127:48] != 0) return MAX48;
      return m[47:0];
   endfunction

   // Fold one interaction into the sums; on tlast queue the frame result and clear
   task automatic absorb_pair(input logic [335:0] d, input logic lst);
      logic [63:0]         mi, mj, m2, r2, r, dmag, c, adx, wmag;
      logic signed [63:0]  dx[3], dv[3], w;
      logic signed [127:0] dot, p;
      logic [127:0]        r3, num, f, j;
      logic [31:0]         pm;
      logic [47:0]         vsq, r2q, r3q, dtff, dtv;
      logic                dneg;
      frame_sums_type      res;
      mi = 64'(d[30:0]);
      mj = 64'(d[61:31]);
      pm = d[285:254];
      vsq = d[333:286];
      r2 = 0;
      r2q = 0;
      r3q = 0;
      for (int k = 0; k < 3; k++) begin
         dx[k] = 64'($signed(d[62 + 32*k +: 32]));
         dv[k] = 64'($signed(d[158 + 32*k +: 32]));
         r2 = r2 + 64'(dx[k] * dx[k]);
      end
      // Coincident pair adds nothing but still counts as the closest approach
      if (r2 != 0) begin
         r = root_floor(r2);
         r3 = 128'(r2) * 128'(r);
         m2 = mi * mj;
         dot = 0;
         for (int k = 0; k < 3; k++) begin
            p = dx[k] * dv[k];
            dot = dot + p;
         end
         dneg = dot[127];
         dmag = dneg ? 64'(-dot) : 64'(dot);
         for (int k = 0; k < 3; k++) begin
            adx = dx[k] < 0 ? 64'(-dx[k]) : 64'(dx[k]);
            num = (128'(m2) * 128'(adx)) << 24;
            f = num / r3;
            c = 64'((128'(3 * adx) * 128'(dmag)) / 128'(r2));
            w = dv[k] - (((dx[k] < 0) != dneg) ? -$signed(c) : $signed(c));
            wmag = w < 0 ? 64'(-w) : 64'(w);
            num = (128'(m2) * 128'(wmag)) << 24;
            j = num / r3;
            force_acc[k] = add_clamped(force_acc[k], clamp_term(f, dx[k] < 0));
            jerk_acc[k] = add_clamped(jerk_acc[k], clamp_term(j, w < 0));
         end
         r2q = r2[63:16];
         r3q = r3[95:48];
      end
      if (r2q < closest_sq) begin
         closest_sq = r2q;
         closest_cube = r3q;
      end
      if (lst) begin
         dtff = pm == 0 ? MAX48 : clamp_step((128'(closest_cube) << 23) / 128'(pm));
         dtv = vsq == 0 ? MAX48 : clamp_step((128'(closest_sq) << 16) / 128'(vsq));
         for (int k = 0; k < 3; k++) begin
            res.frc[k] = force_acc[k];
            res.jrk[k] = jerk_acc[k];
            force_acc[k] = 0;
            jerk_acc[k] = 0;
         end
         res.step = dtff < dtv ? dtff : dtv;
         frames_due.push_back(res);
         closest_sq = MAX48;
         closest_cube = MAX48;
      end
   endtask

   task automatic note_mismatch(input string what, input logic [47:0] want,
                                input logic [47:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch frame %0d %s: expected %h got %h", frame_count, what, want, got);
   endtask

   initial begin
      fail_count = 0;
      frame_count = 0;
      for (int k = 0; k < 3; k++) begin
         force_acc[k] = 0;
         jerk_acc[k] = 0;
      end
      closest_sq = MAX48;
      closest_cube = MAX48;
   end

   assign pending_count = frames_due.size();

   // Predict on each accepted request, compare each accepted result
   always @(posedge clock) begin
      frame_sums_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) absorb_pair(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (frames_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("result with no frame pending: %h", rsp_tdata);
            end else begin
               want = frames_due.pop_front();
               for (int k = 0; k < 3; k++) begin
                  if (rsp_tdata[48*k +: 48] !== want.frc[k])
                     note_mismatch($sformatf("force[%0d]", k), want.frc[k],
                                   rsp_tdata[48*k +: 48]);
                  if (rsp_tdata[144 + 48*k +: 48] !== want.jrk[k])
                     note_mismatch($sformatf("jerk[%0d]", k), want.jrk[k],
                                   rsp_tdata[144 + 48*k +: 48]);
               end
               if (rsp_tdata[335:288] !== want.step)
                  note_mismatch("step_sq", want.step, rsp_tdata[335:288]);
            end
            frame_count++;
         end
      end
   end

endmodule

>>> tb/tb.sv
// Top of the force and jerk accumulator testbench: clock, reset, request and result traffic.
// Depends on nfja_pkg, nbody_force_jerk_accumulator and nbody_force_jerk_accumulator_checker.
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_PAIRS = 1830;
   localparam longint CYCLE_LIMIT = 30_000_000;
   localparam int DRAIN_CYCLES = 3000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [335:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [335:0] rsp_tdata;
   int           fail_count, pending_count, frame_count;
   int           pairs_sent = 0;
   bit           calm = 1'b0;
   longint       cycles = 0;

   nbody_force_jerk_accumulator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   nbody_force_jerk_accumulator_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count), .frame_count(frame_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [335:0] pack_pair(logic [30:0] mi, logic [30:0] mj,
                                              logic [31:0] px, logic [31:0] py,
                                              logic [31:0] pz, logic [31:0] vx,
                                              logic [31:0] vy, logic [31:0] vz,
                                              logic [31:0] pm, logic [47:0] vsq);
      return {2'b00, vsq, pm, vz, vy, vx, pz, py, px, mj, mi};
   endfunction

   // Coordinate spread over all scales, including exact zero and full range
   function automatic logic [31:0] rand_coord();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = 0;
         1, 2: v = $urandom;
         default: begin
            v = $urandom >> $urandom_range(8, 31);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [30:0] rand_mass();
      logic [30:0] m;
      m = 31'($urandom) >> $urandom_range(0, 30);
      return m == 0 ? 31'd1 : m;
   endfunction

   function automatic logic [335:0] rand_pair();
      logic [31:0] pm;
      logic [47:0] vsq;
      pm = $urandom >> $urandom_range(0, 31);
      if (pm == 0) pm = 1;
      vsq = $urandom_range(0, 7) == 0 ? 48'd0
            : 48'({$urandom, $urandom} >> (16 + $urandom_range(0, 47)));
      return pack_pair(rand_mass(), rand_mass(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), pm, vsq);
   endfunction

   // Offer one request after a random gap (none while calm) and hold it until accepted
   task automatic send_pair(input logic [335:0] d, input logic lst);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pairs_sent++;
   endtask

   // Result side: stall a random number of cycles (none while calm) before each result
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      int len;
      int left;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Coincident pair alone, no node velocity
      send_pair(pack_pair(31'h7FFFFFFF, 31'd1, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0,
                          32'd1, 48'd0), 1'b1);
      // Every field at its extreme
      send_pair(pack_pair(31'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF), 1'b1);
      send_pair(pack_pair(31'd1, 31'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h80000000, 32'h80000000, 32'h80000000, 32'd1, 48'd1), 1'b1);
      // Tiny separation, huge mass: saturate terms and sums
      for (int i = 0; i < 4; i++)
         send_pair(pack_pair(31'h7FFFFFFF, 31'h7FFFFFFF, 32'd1, 0, 32'hFFFFFFFF,
                             32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF, 32'd1,
                             48'h1000), i == 3);
      // Coincident pair inside a frame pulls the minimum to zero
      send_pair(pack_pair(31'd12345, 31'd777, 32'h01000000, 32'h00800000, 0,
                          32'h00100000, 0, 32'hFFF00000, 32'h01000000, 48'd0), 1'b0);
      send_pair(pack_pair(31'd5, 31'd9, 0, 0, 0, 32'd3, 32'd4, 32'd5,
                          32'h01000000, 48'h0000_0100_0000), 1'b1);
      // Moderate values, nonzero velocity, mixed signs
      send_pair(pack_pair(31'h01000000, 31'h02000000, 32'hFF000000, 32'h02000000,
                          32'h00400000, 32'h00200000, 32'hFFE00000, 32'h00010000,
                          32'h03000000, 48'h0000_0004_0000), 1'b0);
      send_pair(pack_pair(31'h00800000, 31'h01000000, 32'h00100000, 32'hFFF00000,
                          32'h00080000, 32'hFF000000, 32'h00300000, 32'hFFFFF000,
                          32'h03000000, 48'h0000_0004_0000), 1'b1);
      send_pair(pack_pair(31'h40000000, 31'h00000001, 32'h00000100, 32'h00000200,
                          32'h00000300, 32'h12345678, 32'hEDCBA987, 32'h00000001,
                          32'h80000000, 48'h8000_0000_0000), 1'b1);

      // Random frames, mostly short
      left = RANDOM_PAIRS;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) calm = ~calm;
         len = $urandom_range(0, 3) == 0 ? $urandom_range(4, 8) : $urandom_range(1, 3);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) send_pair(rand_pair(), i == len - 1);
         left -= len;
      end
      @(posedge clock);
      req_tvalid <= 1'b0;

      // Drain outstanding results
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d leaf-pair requests, checked %0d node-pair results",
               pairs_sent, frame_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> nbody_force_jerk_accumulator.f
+incdir+src
src/nfja_pkg.sv
src/nfja_alu.sv
src/nbody_force_jerk_accumulator.sv
src/nfja_checker.sv
tb/nbody_force_jerk_accumulator_checker.sv
tb/tb.sv
